// ----- hdl/dsms_pkg.sv -----
package dsms_pkg;

  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned CURRENT_W = 10;
  localparam int unsigned PULSE_W   = 13;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned CODE_W    = 2;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [ANGLE_W-1:0] ANGLE_MIN  = ANGLE_W'(300);
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = ANGLE_W'(1500);
  localparam logic [PULSE_W-1:0] PULSE_BASE = PULSE_W'(1200);

  localparam logic [PERIOD_W-1:0]  DRIVE_PERIODS_RST = PERIOD_W'(25);
  localparam logic [CURRENT_W-1:0] CURRENT_LIMIT_RST = CURRENT_W'(512);

  // register map, word index taken from paddr[2]
  localparam logic REG_DRIVE_PERIODS = 1'b0;
  localparam logic REG_CURRENT_LIMIT = 1'b1;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // external codes as seen on the result beat
  localparam logic [CODE_W-1:0] MODE_CODE_OFF   = 2'd0;
  localparam logic [CODE_W-1:0] MODE_CODE_DRIVE = 2'd1;
  localparam logic [CODE_W-1:0] MODE_CODE_EXTRA = 2'd2;

  localparam logic [CODE_W-1:0] STAT_READY = 2'd0;
  localparam logic [CODE_W-1:0] STAT_BUSY  = 2'd1;
  localparam logic [CODE_W-1:0] STAT_ERROR = 2'd2;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'b001,
    MODE_DRIVE = 3'b010,
    MODE_EXTRA = 3'b100
  } mode_t;

  typedef struct packed {
    logic                 overcurrent;
    logic                 idle;
    logic [CODE_W-1:0]    status;
    logic [CODE_W-1:0]    drive_mode;
    logic [PULSE_W-1:0]   pulse_two;
    logic [PULSE_W-1:0]   pulse_one;
  } result_t;

  function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
    logic [CODE_W-1:0] c;
    unique case (m)
      MODE_DRIVE: c = MODE_CODE_DRIVE;
      MODE_EXTRA: c = MODE_CODE_EXTRA;
      default:    c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

  function automatic logic [PULSE_W-1:0] angle_to_pulse(input logic [ANGLE_W-1:0] angle);
    logic [ANGLE_W-1:0] a;
    if (angle < ANGLE_MIN) begin
      a = ANGLE_MIN;
    end else if (angle > ANGLE_MAX) begin
      a = ANGLE_MAX;
    end else begin
      a = angle;
    end
    // a <= 1500, so 2a - 1 + 1200 stays below 4200
    return PULSE_BASE + {a[PULSE_W-2:0], 1'b0} - PULSE_W'(1);
  endfunction

endpackage

// ----- hdl/dual_servo_move_supervisor_top.sv -----
// An accepted input beat gives its result beat on out_* in the next cycle.
// Throughput: one beat per cycle; in_tready only drops while a result beat
//   is held by out_tready low, the single output register being the only stage.
// Reset (rst_n low, synchronous): drive off, status ready, period count and
//   stored pulses zero, drive_periods 25, current_limit 512, no result pending.
module dual_servo_move_supervisor_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input beat
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] angle_one, [31:16] angle_two, [41:32] current_one,
  // [51:42] current_two, [55:52] zero
  input  logic [dsms_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] kind
  input  logic                             in_tuser,
  // result beat
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [12:0] pulse_one, [25:13] pulse_two, [27:26] drive_mode, [29:28] status,
  // [30] idle, [31] overcurrent
  output logic [dsms_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import dsms_pkg::*;

  // config registers
  logic [PERIOD_W-1:0]  drive_periods_r;
  logic [CURRENT_W-1:0] current_limit_r;
  logic                 cfg_wr;

  // supervisor state
  mode_t                mode_r, mode_nxt;
  logic [CODE_W-1:0]    status_r, status_nxt;
  logic [PERIOD_W-1:0]  count_r, count_nxt;
  logic [PULSE_W-1:0]   pulse_one_r, pulse_one_nxt;
  logic [PULSE_W-1:0]   pulse_two_r, pulse_two_nxt;

  // output register
  logic                 out_valid_r;
  result_t              result_r, result_nxt;

  logic                 in_acc;
  logic [ANGLE_W-1:0]   angle_one, angle_two;
  logic [CURRENT_W-1:0] current_one, current_two;
  logic [PERIOD_W-1:0]  count_inc;
  logic                 check_due;
  logic                 over_hit;
  logic                 over_flag;

  assign angle_one   = in_tdata[15:0];
  assign angle_two   = in_tdata[31:16];
  assign current_one = in_tdata[41:32];
  assign current_two = in_tdata[51:42];

  // a held result does not block the input unless it is stalled
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // ---- APB: pready tied high, word select on paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      REG_DRIVE_PERIODS: cfg_prdata = {{(32-PERIOD_W){1'b0}}, drive_periods_r};
      REG_CURRENT_LIMIT: cfg_prdata = {{(32-CURRENT_W){1'b0}}, current_limit_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_periods_r <= DRIVE_PERIODS_RST;
      current_limit_r <= CURRENT_LIMIT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_DRIVE_PERIODS) begin
        drive_periods_r <= cfg_pwdata[PERIOD_W-1:0];
      end else begin
        current_limit_r <= cfg_pwdata[CURRENT_W-1:0];
      end
    end
  end

  // ---- next state for one beat
  // count wraps at 16 bits; a lowered drive_periods triggers the check at once
  assign count_inc = count_r + PERIOD_W'(1);
  assign check_due = count_inc >= drive_periods_r;
  assign over_hit  = (current_one >= current_limit_r) || (current_two >= current_limit_r);

  always_comb begin
    mode_nxt      = mode_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    pulse_one_nxt = pulse_one_r;
    pulse_two_nxt = pulse_two_r;
    over_flag     = 1'b0;

    if (in_tuser == KIND_MOVE) begin
      // move while driving keeps the running count
      pulse_one_nxt = angle_to_pulse(angle_one);
      pulse_two_nxt = angle_to_pulse(angle_two);
      mode_nxt      = MODE_DRIVE;
      status_nxt    = STAT_BUSY;
    end else if (mode_r != MODE_OFF) begin
      count_nxt = count_inc;
      if (check_due) begin
        count_nxt = '0;
        if (over_hit) begin
          over_flag = 1'b1;
          if (mode_r == MODE_EXTRA) begin
            // second overload in a row
            mode_nxt   = MODE_OFF;
            status_nxt = STAT_ERROR;
          end else begin
            mode_nxt = MODE_EXTRA;
          end
        end else begin
          mode_nxt   = MODE_OFF;
          status_nxt = STAT_READY;
        end
      end
    end
    // tick while off: nothing moves

    result_nxt.pulse_one   = pulse_one_nxt;
    result_nxt.pulse_two   = pulse_two_nxt;
    result_nxt.drive_mode  = mode_code(mode_nxt);
    result_nxt.status      = status_nxt;
    result_nxt.idle        = (mode_nxt == MODE_OFF);
    result_nxt.overcurrent = over_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      status_r    <= STAT_READY;
      count_r     <= '0;
      pulse_one_r <= '0;
      pulse_two_r <= '0;
    end else if (in_acc) begin
      mode_r      <= mode_nxt;
      status_r    <= status_nxt;
      count_r     <= count_nxt;
      pulse_one_r <= pulse_one_nxt;
      pulse_two_r <= pulse_two_nxt;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

endmodule

// ----- hdl/dsms_checker.sv -----
module dsms_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dsms_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dsms_pkg::*;

  logic [CODE_W-1:0] mode_f;
  logic [CODE_W-1:0] stat_f;
  logic              idle_f;
  logic              over_f;

  assign mode_f = out_tdata[27:26];
  assign stat_f = out_tdata[29:28];
  assign idle_f = out_tdata[30];
  assign over_f = out_tdata[31];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_idle_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> idle_f == (mode_f == MODE_CODE_OFF))
    else $error("idle disagrees with drive mode");

  // an overload check never leaves the drive in plain driving
  a_over_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && over_f |-> mode_f != MODE_CODE_DRIVE)
    else $error("overcurrent with drive still in normal mode");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mode_f != MODE_CODE_OFF |-> stat_f == STAT_BUSY)
    else $error("drive on without busy status");

  // error sticks through ignored ticks, so only the drive state is tied to it
  a_error_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stat_f == STAT_ERROR |-> mode_f == MODE_CODE_OFF)
    else $error("error status without drive off");

endmodule

bind dual_servo_move_supervisor_top dsms_checker u_dsms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- dv/tb_dual_servo_move_supervisor_top.sv -----
module tb_dual_servo_move_supervisor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsms_pkg::*;

  // watchdog, in clock cycles
  localparam int unsigned CYCLE_LIMIT = 200000;
  // input beats wanted over the whole run
  localparam int unsigned RANDOM_BEATS = 550;

  // one pending input beat, still unpacked
  typedef struct {
    logic                 kind;
    logic [ANGLE_W-1:0]   angle_one;
    logic [ANGLE_W-1:0]   angle_two;
    logic [CURRENT_W-1:0] current_one;
    logic [CURRENT_W-1:0] current_two;
  } servo_cmd_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [2:0]            cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  dual_servo_move_supervisor_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: own copy of the registers and of the supervisor state
  // ---------------------------------------------------------------------
  logic [PERIOD_W-1:0]  cfg_periods = DRIVE_PERIODS_RST;
  logic [CURRENT_W-1:0] cfg_limit   = CURRENT_LIMIT_RST;
  logic [CODE_W-1:0]    drv_mode    = MODE_CODE_OFF;
  logic [CODE_W-1:0]    drv_status  = STAT_READY;
  logic [PERIOD_W-1:0]  tick_cnt    = '0;
  logic [PULSE_W-1:0]   pulse1      = '0;
  logic [PULSE_W-1:0]   pulse2      = '0;

  servo_cmd_t cmd_q[$];             // beats waiting for the driver
  result_t    pending_status_q[$];  // predicted result beats, oldest first

  // run bookkeeping
  int unsigned faults        = 0;
  int unsigned beats_in      = 0;
  int unsigned beats_live    = 0;   // beats not ignored by the block
  int unsigned results_seen  = 0;
  int unsigned over_seen     = 0;
  int unsigned error_stops   = 0;
  int unsigned reg_writes    = 0;

  // idling switches, set per phase
  bit in_gaps_on    = 1'b0;
  bit out_stalls_on = 1'b0;

  // clamp to the legal angle window, then 2a - 1 above the base count
  function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANGLE_W-1:0] ang);
    int a;
    a = int'(ang);
    if (a < int'(ANGLE_MIN)) a = int'(ANGLE_MIN);
    else if (a > int'(ANGLE_MAX)) a = int'(ANGLE_MAX);
    return PULSE_W'(int'(PULSE_BASE) + 2 * a - 1);
  endfunction

  // advance the supervisor by one beat and return the status beat it gives
  function automatic result_t servo_step(input servo_cmd_t c);
    result_t r;
    r = '0;
    if (c.kind == KIND_MOVE) begin
      pulse1     = pulse_of(c.angle_one);
      pulse2     = pulse_of(c.angle_two);
      drv_mode   = MODE_CODE_DRIVE;
      drv_status = STAT_BUSY;
    end else if (drv_mode != MODE_CODE_OFF) begin
      tick_cnt = tick_cnt + 1'b1;
      // >= so that a period count lowered below the running count checks now
      if (tick_cnt >= cfg_periods) begin
        tick_cnt = '0;
        if (c.current_one >= cfg_limit || c.current_two >= cfg_limit) begin
          r.overcurrent = 1'b1;
          if (drv_mode == MODE_CODE_EXTRA) begin
            drv_status = STAT_ERROR;
            drv_mode   = MODE_CODE_OFF;
          end else begin
            drv_mode = MODE_CODE_EXTRA;
          end
        end else begin
          drv_mode   = MODE_CODE_OFF;
          drv_status = STAT_READY;
        end
      end
    end
    r.pulse_one  = pulse1;
    r.pulse_two  = pulse2;
    r.drive_mode = drv_mode;
    r.status     = drv_status;
    r.idle       = (drv_mode == MODE_CODE_OFF);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: changes on the falling edge, fed from cmd_q
  // ---------------------------------------------------------------------
  logic        in_acc = 1'b0;   // beat taken at the last rising edge
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    servo_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!in_tvalid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= c.kind;
        in_tdata  <= {4'b0, c.current_two, c.current_one, c.angle_two, c.angle_one};
        gap_left = pick_gap(in_gaps_on);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 99) < 25) stall_left = pick_gap(1'b1);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge. Results are checked
  // before the new input beat is predicted; a result can never belong to
  // a beat taken on the same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t    got;
    result_t    want;
    servo_cmd_t c;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_seen++;
        if (pending_status_q.size() == 0) begin
          $error("result beat %h with nothing expected", out_tdata);
          faults++;
        end else begin
          want = pending_status_q.pop_front();
          check_field("pulse_one",   want.pulse_one,   got.pulse_one);
          check_field("pulse_two",   want.pulse_two,   got.pulse_two);
          check_field("drive_mode",  want.drive_mode,  got.drive_mode);
          check_field("status",      want.status,      got.status);
          check_field("idle",        want.idle,        got.idle);
          check_field("overcurrent", want.overcurrent, got.overcurrent);
        end
      end
      if (in_tvalid && in_tready) begin
        c.kind        = in_tuser;
        c.angle_one   = in_tdata[15:0];
        c.angle_two   = in_tdata[31:16];
        c.current_one = in_tdata[41:32];
        c.current_two = in_tdata[51:42];
        beats_in++;
        // ticks while off do nothing, so they don't count as real work
        if (!(c.kind == KIND_TICK && drv_mode == MODE_CODE_OFF)) beats_live++;
        want = servo_step(c);
        if (want.overcurrent) over_seen++;
        if (want.overcurrent && want.status == STAT_ERROR) error_stops++;
        pending_status_q.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_cmd(input logic kind, input int unsigned a1, input int unsigned a2,
                          input int unsigned c1, input int unsigned c2);
    servo_cmd_t c;
    c.kind        = kind;
    c.angle_one   = ANGLE_W'(a1);
    c.angle_two   = ANGLE_W'(a2);
    c.current_one = CURRENT_W'(c1);
    c.current_two = CURRENT_W'(c2);
    cmd_q.push_back(c);
  endtask

  // APB write, then read back; only called with the block drained
  task automatic reg_write(input logic idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    reg_writes++;
    if (idx == REG_DRIVE_PERIODS) begin
      cfg_periods = val[PERIOD_W-1:0];
      want = {16'b0, cfg_periods};
    end else begin
      cfg_limit = val[CURRENT_W-1:0];
      want = {22'b0, cfg_limit};
    end
    // read back
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field(idx == REG_DRIVE_PERIODS ? "drive_periods" : "current_limit", want, rd);
  endtask

  // junk above the field width must be dropped by the block
  task automatic configure(input int unsigned periods, input int unsigned limit);
    logic [31:0] junk;
    junk = $urandom();
    reg_write(REG_DRIVE_PERIODS, {junk[31:16], PERIOD_W'(periods)});
    junk = $urandom();
    reg_write(REG_CURRENT_LIMIT, {junk[31:10], CURRENT_W'(limit)});
  endtask

  // sender holds off until every predicted beat has been seen
  task automatic drain();
    do @(posedge clk);
    while (cmd_q.size() != 0 || in_tvalid || pending_status_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic int unsigned rand_angle();
    int unsigned r;
    int unsigned edges[8] = '{0, 299, 300, 301, 1499, 1500, 1501, 65535};
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(0, 65535);
    if (r < 7) return $urandom_range(300, 1500);
    return edges[$urandom_range(0, 7)];
  endfunction

  // currents aimed around the live limit, with some fully random
  function automatic int unsigned rand_current(input bit over);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    if (over || cfg_limit == 0) return $urandom_range(cfg_limit, 1023);
    return $urandom_range(0, cfg_limit - 1);
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned r;
    int unsigned p;
    int unsigned lim;
    bit          over;

    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: clamp edges, move while driving, both overcurrent paths
    configure(2, 512);
    push_cmd(KIND_TICK, 65535, 65535, 1023, 1023);   // tick while off
    push_cmd(KIND_MOVE, 0, 65535, 1023, 1023);
    push_cmd(KIND_MOVE, 299, 1501, 0, 0);
    push_cmd(KIND_MOVE, 300, 1500, 0, 0);            // move while driving
    push_cmd(KIND_TICK, 0, 0, 511, 0);
    push_cmd(KIND_TICK, 0, 0, 0, 511);               // check just under: ready
    push_cmd(KIND_MOVE, 1000, 800, 0, 0);
    push_cmd(KIND_TICK, 0, 0, 0, 0);
    push_cmd(KIND_TICK, 0, 0, 512, 0);               // first overcurrent: extra
    push_cmd(KIND_MOVE, 1499, 301, 0, 0);            // back to driving from extra
    push_cmd(KIND_TICK, 0, 0, 0, 0);
    push_cmd(KIND_TICK, 0, 0, 0, 1023);
    push_cmd(KIND_TICK, 65535, 65535, 0, 0);
    push_cmd(KIND_TICK, 0, 0, 1023, 1023);           // second overcurrent: error
    push_cmd(KIND_TICK, 0, 0, 0, 0);
    drain();

    // zero period count and zero limit: every tick checks and trips
    configure(0, 0);
    push_cmd(KIND_MOVE, 1500, 300, 0, 0);
    push_cmd(KIND_TICK, 0, 0, 0, 0);
    push_cmd(KIND_TICK, 0, 0, 0, 0);
    drain();
    configure(1, 1023);
    push_cmd(KIND_MOVE, 700, 1200, 0, 0);
    push_cmd(KIND_TICK, 0, 0, 1022, 1022);
    drain();

    // longest period, then lowered under the running count
    configure(65535, 600);
    push_cmd(KIND_MOVE, 900, 900, 0, 0);
    repeat (5) push_cmd(KIND_TICK, 0, 0, 1023, 1023);
    drain();
    configure(3, 600);
    push_cmd(KIND_TICK, 0, 0, 599, 599);
    drain();

    // random phases, each with its own settings and idling mix
    ph = 0;
    while (beats_in < RANDOM_BEATS) begin
      r = $urandom_range(0, 19);
      if (r == 0)      p = $urandom_range(0, 1);
      else if (r < 12) p = $urandom_range(2, 8);
      else if (r < 17) p = $urandom_range(9, 30);
      else if (r < 19) p = 5;
      else             p = 65535;
      r = $urandom_range(0, 9);
      if (r == 0)      lim = 0;
      else if (r == 1) lim = 1023;
      else             lim = $urandom_range(0, 1023);
      configure(p, lim);
      in_gaps_on    = (ph % 3) != 0;
      out_stalls_on = (ph % 4) != 1;
      n = $urandom_range(40, 60);
      // each phase opens with a move so the ticks have something to do
      push_cmd(KIND_MOVE, rand_angle(), rand_angle(), $urandom_range(0, 1023),
               $urandom_range(0, 1023));
      repeat (n) begin
        if ($urandom_range(0, 99) < 18) begin
          push_cmd(KIND_MOVE, rand_angle(), rand_angle(), $urandom_range(0, 1023),
                   $urandom_range(0, 1023));
        end else begin
          over = $urandom_range(0, 99) < 35;
          if ($urandom_range(0, 1)) begin
            push_cmd(KIND_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     rand_current(over), rand_current(1'b0));
          end else begin
            push_cmd(KIND_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     rand_current(1'b0), rand_current(over));
          end
        end
      end
      drain();
      ph++;
    end

    $display("%0d input beats (%0d acted on) over %0d random phases, %0d results checked",
             beats_in, beats_live, ph, results_seen);
    $display("%0d overcurrent checks, %0d error stops, %0d register writes, %0d mismatches",
             over_seen, error_stops, reg_writes, faults);
    if (faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- dual_servo_move_supervisor_top.f -----
hdl/dsms_pkg.sv
hdl/dual_servo_move_supervisor_top.sv
hdl/dsms_checker.sv
dv/tb_dual_servo_move_supervisor_top.sv
